>>> rtl/sfd_pkg.sv
// sfd_pkg: payload types and character codes for the sample format descriptor parser
// no dependencies; used by rtl/sample_format_descriptor_parser.sv
package sfd_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic        endian_be;
    logic        is_signed_value;
    logic [6:0]  real_bits;
    logic [6:0]  storage_bits;
    logic [30:0] repeat_count;
    logic [5:0]  shift_amount;
  } out_t;

  localparam int unsigned NUM_W    = 31;
  localparam int unsigned BITS_W   = 7;
  localparam logic [NUM_W-1:0]  NUM_MAX  = 31'h7FFF_FFFF;
  localparam logic [BITS_W-1:0] BITS_MAX = 7'd64;
  localparam logic [BITS_W-1:0] BITS_SAT = 7'd127;

  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

>>> rtl/sample_format_descriptor_parser.sv
// sample_format_descriptor_parser: character-serial parser for
// [be|le]:[s|u]<real>/<storage>[X<repeat>][>><shift>] descriptors
// depends on rtl/sfd_pkg.sv
//
// usage
// - in_valid/in_ready/in_data carry one descriptor character per transaction;
//   in_data.last_char marks the final character of a descriptor
// - out_valid/out_ready/out_data carry one parse result per descriptor,
//   produced by the transaction that carries the last character
// - throughput: one character per cycle while in_ready is high; the parse
//   state, the decimal accumulate (acc * 10 + digit) and the final range
//   checks all sit between the parse state registers and the result register
// - latency: the result is visible in out_data the cycle after the last
//   character is accepted
// - when the receiver stalls, the result is held in the output register;
//   characters, the last one included, are taken only while the output
//   register is empty or being drained (in_ready = !out_valid | out_ready)
// - reset (rst_n low, synchronous) returns the parser to the first prefix
//   character and empties the output register
// - after each last character the parser returns to its reset state
module sample_format_descriptor_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sfd_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sfd_pkg::out_t out_data
);

  // parse phases
  localparam logic [3:0] PH_FIRST  = 4'd0;
  localparam logic [3:0] PH_E      = 4'd1;
  localparam logic [3:0] PH_COLON  = 4'd2;
  localparam logic [3:0] PH_SIGN   = 4'd3;
  localparam logic [3:0] PH_REAL   = 4'd4;
  localparam logic [3:0] PH_STORE  = 4'd5;
  localparam logic [3:0] PH_REPEAT = 4'd6;
  localparam logic [3:0] PH_GT     = 4'd7;
  localparam logic [3:0] PH_SHIFT  = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;

  localparam int unsigned NW = sfd_pkg::NUM_W;
  localparam int unsigned BW = sfd_pkg::BITS_W;

  // parse state
  logic [3:0]    phase_r, phase_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic          seen_r, seen_nxt;
  logic          ovf_r, ovf_nxt;
  logic          endian_r, endian_nxt;
  logic          sign_r, sign_nxt;
  // bit counts saturate at 127: any value above 64 fails the same checks
  logic [BW-1:0] real_r, real_nxt;
  logic [BW-1:0] store_r, store_nxt;
  logic [BW-1:0] shift_r, shift_nxt;
  logic [NW-1:0] rep_r, rep_nxt;
  logic          fail_r, fail_nxt;

  logic          out_valid_r;
  sfd_pkg::out_t out_data_r;
  sfd_pkg::out_t res;

  logic          accept;
  logic [7:0]    ch;
  logic          is_digit;
  logic [NW+3:0] mac;
  logic [BW:0]   sum;
  logic [NW-1:0] rep_fix;
  logic          ok;

  function automatic logic [BW-1:0] sat_bits(input logic [NW-1:0] v);
    sat_bits = (v > NW'(sfd_pkg::BITS_SAT)) ? sfd_pkg::BITS_SAT : v[BW-1:0];
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign ch       = in_data.char_code;
  assign is_digit = (ch >= sfd_pkg::CH_ZERO) && (ch <= sfd_pkg::CH_NINE);
  // acc * 10 + digit, as shift-and-add; ascii digits carry their value in the low nibble
  assign mac      = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + (NW+4)'(ch[3:0]);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    ovf_nxt    = ovf_r;
    endian_nxt = endian_r;
    sign_nxt   = sign_r;
    real_nxt   = real_r;
    store_nxt  = store_r;
    shift_nxt  = shift_r;
    rep_nxt    = rep_r;
    fail_nxt   = fail_r;
    res        = '0;
    sum        = '0;
    rep_fix    = '0;
    ok         = 1'b0;

    // character step
    if (accept && !fail_r) begin
      if (is_digit && (phase_r == PH_REAL || phase_r == PH_STORE ||
                       phase_r == PH_REPEAT || phase_r == PH_SHIFT)) begin
        if (mac > (NW+4)'(sfd_pkg::NUM_MAX)) begin
          acc_nxt = sfd_pkg::NUM_MAX;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = mac[NW-1:0];
        end
        seen_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_FIRST: begin
            if (ch == sfd_pkg::CH_B) begin
              endian_nxt = 1'b1;
              phase_nxt  = PH_E;
            end else if (ch == sfd_pkg::CH_L) begin
              endian_nxt = 1'b0;
              phase_nxt  = PH_E;
            end else begin
              fail_nxt = 1'b1;
            end
          end
          PH_E: begin
            if (ch == sfd_pkg::CH_E) phase_nxt = PH_COLON;
            else fail_nxt = 1'b1;
          end
          PH_COLON: begin
            if (ch == sfd_pkg::CH_COLON) phase_nxt = PH_SIGN;
            else fail_nxt = 1'b1;
          end
          PH_SIGN: begin
            if (ch == sfd_pkg::CH_S) begin
              sign_nxt  = 1'b1;
              phase_nxt = PH_REAL;
            end else if (ch == sfd_pkg::CH_U) begin
              sign_nxt  = 1'b0;
              phase_nxt = PH_REAL;
            end else begin
              fail_nxt = 1'b1;
            end
          end
          PH_REAL: begin
            if (ch == sfd_pkg::CH_SLASH && seen_r) begin
              real_nxt  = sat_bits(acc_r);
              fail_nxt  = ovf_r;
              acc_nxt   = '0;
              seen_nxt  = 1'b0;
              ovf_nxt   = 1'b0;
              phase_nxt = PH_STORE;
            end else begin
              fail_nxt = 1'b1;
            end
          end
          PH_STORE: begin
            store_nxt = sat_bits(acc_r);
            fail_nxt  = !seen_r || ovf_r;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            if (ch == sfd_pkg::CH_X) phase_nxt = PH_REPEAT;
            else if (ch == sfd_pkg::CH_GT) phase_nxt = PH_GT;
            else phase_nxt = PH_DONE;
          end
          PH_REPEAT: begin
            rep_nxt   = acc_r;
            fail_nxt  = !seen_r || ovf_r;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            phase_nxt = (ch == sfd_pkg::CH_GT) ? PH_GT : PH_DONE;
          end
          PH_GT: begin
            phase_nxt = (ch == sfd_pkg::CH_GT) ? PH_SHIFT : PH_DONE;
          end
          PH_SHIFT: begin
            shift_nxt = sat_bits(acc_r);
            fail_nxt  = !seen_r || ovf_r;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            phase_nxt = PH_DONE;
          end
          default: begin
          end
        endcase
      end
    end

    // end of descriptor: close any open number, check ranges, rearm
    if (accept && in_data.last_char) begin
      if (!fail_nxt) begin
        case (phase_nxt)
          PH_STORE: begin
            store_nxt = sat_bits(acc_nxt);
            fail_nxt  = !seen_nxt || ovf_nxt;
          end
          PH_REPEAT: begin
            rep_nxt  = acc_nxt;
            fail_nxt = !seen_nxt || ovf_nxt;
          end
          PH_SHIFT: begin
            shift_nxt = sat_bits(acc_nxt);
            fail_nxt  = !seen_nxt || ovf_nxt;
          end
          PH_GT, PH_DONE: begin
          end
          default: fail_nxt = 1'b1;
        endcase
      end

      // zero repeat count means one
      rep_fix = (rep_nxt == '0) ? NW'(1) : rep_nxt;
      sum     = {1'b0, real_nxt} + {1'b0, shift_nxt};
      ok      = !fail_nxt &&
                store_nxt >= BW'(1) && store_nxt <= sfd_pkg::BITS_MAX &&
                real_nxt  >= BW'(1) && real_nxt  <= sfd_pkg::BITS_MAX &&
                sum <= {1'b0, store_nxt};

      if (ok) begin
        res.valid_res       = 1'b1;
        res.endian_be       = endian_nxt;
        res.is_signed_value = sign_nxt;
        res.real_bits       = real_nxt;
        res.storage_bits    = store_nxt;
        res.repeat_count    = rep_fix;
        res.shift_amount    = shift_nxt[5:0];
      end

      phase_nxt  = PH_FIRST;
      acc_nxt    = '0;
      seen_nxt   = 1'b0;
      ovf_nxt    = 1'b0;
      endian_nxt = 1'b0;
      sign_nxt   = 1'b0;
      real_nxt   = '0;
      store_nxt  = '0;
      shift_nxt  = '0;
      rep_nxt    = NW'(1);
      fail_nxt   = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      ovf_r    <= 1'b0;
      endian_r <= 1'b0;
      sign_r   <= 1'b0;
      real_r   <= '0;
      store_r  <= '0;
      shift_r  <= '0;
      rep_r    <= NW'(1);
      fail_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      ovf_r    <= ovf_nxt;
      endian_r <= endian_nxt;
      sign_r   <= sign_nxt;
      real_r   <= real_nxt;
      store_r  <= store_nxt;
      shift_r  <= shift_nxt;
      rep_r    <= rep_nxt;
      fail_r   <= fail_nxt;
    end
  end

  // result register: loaded by the last character, held while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_data.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_char) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for sample_format_descriptor_parser
// drives descriptor characters, predicts each parse result and checks it field by field
// depends on rtl/sfd_pkg.sv and rtl/sample_format_descriptor_parser.sv
`timescale 1ns / 1ps

module tb_top;

  // where the predictor is in the descriptor grammar
  localparam logic [3:0] ST_PREFIX  = 4'd0;
  localparam logic [3:0] ST_E       = 4'd1;
  localparam logic [3:0] ST_COLON   = 4'd2;
  localparam logic [3:0] ST_SIGN    = 4'd3;
  localparam logic [3:0] ST_REAL    = 4'd4;
  localparam logic [3:0] ST_STORAGE = 4'd5;
  localparam logic [3:0] ST_REPEAT  = 4'd6;
  localparam logic [3:0] ST_GT      = 4'd7;
  localparam logic [3:0] ST_SHIFT   = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  sfd_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  sfd_pkg::out_t out_data;

  // predicted parse results, oldest first
  sfd_pkg::out_t pending_formats[$];
  sfd_pkg::out_t want;
  int    mismatches = 0;
  int    chars_sent = 0;
  // when set, neither side inserts idle cycles
  bit    calm = 1'b0;

  // characters of the descriptor being built
  logic [7:0] desc_q[$];

  // predictor state
  logic [3:0]   state;
  logic [30:0]  acc;
  bit           have_digit;
  bit           too_big;
  bit           is_be;
  bit           is_signed_fmt;
  bit           bad;
  logic [30:0]  real_q;
  logic [30:0]  store_q;
  logic [30:0]  rep_q;
  logic [30:0]  shift_q;

  sample_format_descriptor_parser u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_parse();
    state         = ST_PREFIX;
    acc           = '0;
    have_digit    = 1'b0;
    too_big       = 1'b0;
    is_be         = 1'b0;
    is_signed_fmt = 1'b0;
    real_q        = '0;
    store_q       = '0;
    rep_q         = 31'd1;
    shift_q       = '0;
    bad           = 1'b0;
  endtask

  // decimal accumulate, saturating at the largest 31-bit value
  task automatic add_digit(input logic [3:0] d);
    logic [35:0] v;
    v = acc * 36'd10 + d;
    if (v > sfd_pkg::NUM_MAX) begin
      too_big = 1'b1;
      v       = 36'(sfd_pkg::NUM_MAX);
    end
    acc        = v[30:0];
    have_digit = 1'b1;
  endtask

  // close a digit run; an empty or oversized number spoils the descriptor
  function automatic logic [30:0] take_number();
    logic [30:0] v;
    v = acc;
    if (!have_digit || too_big) bad = 1'b1;
    acc        = '0;
    have_digit = 1'b0;
    too_big    = 1'b0;
    return v;
  endfunction

  // advance the grammar by one character; on the last one produce the result
  task automatic parse_char(input sfd_pkg::in_t item, output bit gives,
                            output sfd_pkg::out_t res);
    logic [7:0]  c;
    bit          digit;
    logic [31:0] sum;
    c     = item.char_code;
    digit = (c >= sfd_pkg::CH_ZERO) && (c <= sfd_pkg::CH_NINE);
    gives = 1'b0;
    res   = '0;
    // once the grammar is broken every later character is ignored
    if (!bad) begin
      case (state)
        ST_PREFIX: begin
          if (c == sfd_pkg::CH_B) begin
            is_be = 1'b1;
            state = ST_E;
          end else if (c == sfd_pkg::CH_L) begin
            is_be = 1'b0;
            state = ST_E;
          end else begin
            bad = 1'b1;
          end
        end
        ST_E: begin
          if (c == sfd_pkg::CH_E) state = ST_COLON;
          else bad = 1'b1;
        end
        ST_COLON: begin
          if (c == sfd_pkg::CH_COLON) state = ST_SIGN;
          else bad = 1'b1;
        end
        ST_SIGN: begin
          if (c == sfd_pkg::CH_S) begin
            is_signed_fmt = 1'b1;
            state         = ST_REAL;
          end else if (c == sfd_pkg::CH_U) begin
            is_signed_fmt = 1'b0;
            state         = ST_REAL;
          end else begin
            bad = 1'b1;
          end
        end
        ST_REAL: begin
          if (digit) begin
            add_digit(4'(c - sfd_pkg::CH_ZERO));
          end else if (c == sfd_pkg::CH_SLASH && have_digit) begin
            real_q = take_number();
            state  = ST_STORAGE;
          end else begin
            bad = 1'b1;
          end
        end
        ST_STORAGE: begin
          if (digit) begin
            add_digit(4'(c - sfd_pkg::CH_ZERO));
          end else begin
            store_q = take_number();
            if (c == sfd_pkg::CH_X) state = ST_REPEAT;
            else if (c == sfd_pkg::CH_GT) state = ST_GT;
            else state = ST_DONE;
          end
        end
        ST_REPEAT: begin
          if (digit) begin
            add_digit(4'(c - sfd_pkg::CH_ZERO));
          end else begin
            rep_q = take_number();
            state = (c == sfd_pkg::CH_GT) ? ST_GT : ST_DONE;
          end
        end
        // a lone '>' ends the grammar
        ST_GT: begin
          state = (c == sfd_pkg::CH_GT) ? ST_SHIFT : ST_DONE;
        end
        ST_SHIFT: begin
          if (digit) begin
            add_digit(4'(c - sfd_pkg::CH_ZERO));
          end else begin
            shift_q = take_number();
            state   = ST_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (item.last_char) begin
      // close whatever number is still open, anything earlier is a short descriptor
      if (!bad) begin
        case (state)
          ST_STORAGE: store_q = take_number();
          ST_REPEAT:  rep_q   = take_number();
          ST_SHIFT:   shift_q = take_number();
          ST_GT, ST_DONE: begin
          end
          default:    bad = 1'b1;
        endcase
      end
      if (rep_q == '0) rep_q = 31'd1;
      // full-width sum, no wrap
      sum   = {1'b0, real_q} + {1'b0, shift_q};
      gives = 1'b1;
      if (!bad && store_q >= 1 && store_q <= sfd_pkg::BITS_MAX && real_q >= 1 &&
          real_q <= sfd_pkg::BITS_MAX && sum <= {1'b0, store_q}) begin
        res.valid_res       = 1'b1;
        res.endian_be       = is_be;
        res.is_signed_value = is_signed_fmt;
        res.real_bits       = real_q[6:0];
        res.storage_bits    = store_q[6:0];
        res.repeat_count    = rep_q;
        res.shift_amount    = shift_q[5:0];
      end
      clear_parse();
    end
  endtask

  // ---------------------------------------------------------------------------
  // idle insertion: mostly none or short, a few long
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one character transaction; valid is never dropped and raised in one step
  task automatic send_char(input logic [7:0] code, input logic last);
    int            gap;
    sfd_pkg::in_t  item;
    bit            gives;
    sfd_pkg::out_t res;
    gap            = pick_gap();
    item.char_code = code;
    item.last_char = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    parse_char(item, gives, res);
    if (gives) pending_formats.push_back(res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_desc();
    for (int i = 0; i < desc_q.size(); i++) send_char(desc_q[i], i == desc_q.size() - 1);
  endtask

  // decimal text, sometimes with leading zeros
  task automatic push_number(input longint unsigned v);
    logic [7:0] digits[$];
    int         zeros;
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) desc_q.push_back(sfd_pkg::CH_ZERO);
    if (v == 0) digits.push_front(sfd_pkg::CH_ZERO);
    while (v != 0) begin
      digits.push_front(8'(sfd_pkg::CH_ZERO + v % 10));
      v = v / 10;
    end
    foreach (digits[i]) desc_q.push_back(digits[i]);
  endtask

  // count values from zero through past the 31-bit limit
  function automatic longint unsigned pick_count();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(1, 9);
      2: return $urandom_range(10, 100000);
      3: return $urandom;
      4: return 64'(sfd_pkg::NUM_MAX);
      5: return 64'(sfd_pkg::NUM_MAX) + 1;
      6: return 64'd99999999999;
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  // mostly well-formed descriptor with random content, some broken on purpose
  task automatic build_descriptor();
    longint unsigned store, realv, shiftv;
    int              r;
    logic [7:0]      junk;
    desc_q.delete();
    store  = $urandom_range(1, 64);
    realv  = $urandom_range(1, 32'(store));
    shiftv = $urandom_range(0, 32'(store - realv));
    r = $urandom_range(0, 99);
    // range violations: storage, real bits, and real plus shift past storage
    if (r < 7) begin
      case ($urandom_range(0, 4))
        0: store = 0;
        1: store = 65;
        2: store = 127;
        3: store = 128;
        default: store = 64'd4294967360;
      endcase
    end else if (r < 13) begin
      realv = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 200);
    end else if (r < 19) begin
      shiftv = store - realv + $urandom_range(1, 10);
    end

    desc_q.push_back($urandom_range(0, 1) ? sfd_pkg::CH_B : sfd_pkg::CH_L);
    desc_q.push_back(sfd_pkg::CH_E);
    desc_q.push_back(sfd_pkg::CH_COLON);
    desc_q.push_back($urandom_range(0, 1) ? sfd_pkg::CH_S : sfd_pkg::CH_U);
    if ($urandom_range(0, 29) != 0) push_number(realv);
    desc_q.push_back(sfd_pkg::CH_SLASH);
    push_number(store);

    // optional repeat, possibly with no digits
    if ($urandom_range(0, 9) < 4) begin
      desc_q.push_back(sfd_pkg::CH_X);
      if ($urandom_range(0, 9) != 0) push_number(pick_count());
    end
    // optional shift, or a lone '>' that cuts the grammar short
    r = $urandom_range(0, 99);
    if (r < 40) begin
      desc_q.push_back(sfd_pkg::CH_GT);
      desc_q.push_back(sfd_pkg::CH_GT);
      if ($urandom_range(0, 9) != 0) begin
        push_number(($urandom_range(0, 6) == 0) ? pick_count() : shiftv);
      end
    end else if (r < 46) begin
      desc_q.push_back(sfd_pkg::CH_GT);
      desc_q.push_back(sfd_pkg::CH_SLASH);
      push_number(shiftv);
    end
    // trailing characters past the grammar
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4)) desc_q.push_back(8'($urandom_range(0, 255)));
    end

    // broken variants: one character replaced, or the text cut short
    r = $urandom_range(0, 99);
    if (r < 12) begin
      desc_q[$urandom_range(0, desc_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 20) begin
      r = $urandom_range(1, desc_q.size());
      while (desc_q.size() > r) junk = desc_q.pop_back();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a short valid descriptor, one with field extremes, and descriptors ended at once
  task automatic test_directed();
    send_text("le:u8/8");
    // real 1, storage 64, repeat 0 taken as 1, shift 63 filling storage exactly
    send_text("be:s1/64X0>>63");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_descriptors(input int n_chars, input bit quiet);
    int stop_at;
    calm    = quiet;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      build_descriptor();
      send_desc();
    end
    calm = 1'b0;
  endtask

  // arbitrary bytes with random last markers, closed by a last one
  task automatic test_noise(input int n_chars);
    repeat (n_chars - 1) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    send_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_parse();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_descriptors(500, 1'b0);
    test_descriptors(200, 1'b1);
    test_noise(150);
    test_descriptors(400, 1'b0);
    in_valid <= 1'b0;

    // drain, then give a late or extra result time to show up
    while (pending_formats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: ready runs broken by stalls, sometimes long ones
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int run, stall;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // every result transaction is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_formats.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
      end else begin
        want = pending_formats.pop_front();
        check_field("valid_res", 64'(want.valid_res), 64'(out_data.valid_res));
        check_field("endian_be", 64'(want.endian_be), 64'(out_data.endian_be));
        check_field("is_signed_value", 64'(want.is_signed_value),
                    64'(out_data.is_signed_value));
        check_field("real_bits", 64'(want.real_bits), 64'(out_data.real_bits));
        check_field("storage_bits", 64'(want.storage_bits), 64'(out_data.storage_bits));
        check_field("repeat_count", 64'(want.repeat_count), 64'(out_data.repeat_count));
        check_field("shift_amount", 64'(want.shift_amount), 64'(out_data.shift_amount));
      end
    end
  end

  // hang guard
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
